// File: rtl/fpd_pkg.sv
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants of the framed packet deframer
// Result codes, configuration register indexes, record types and the
// byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package fpd_pkg;

  // Header layout and payload bound.
  localparam int HEADER_BYTES  = 12;
  localparam int PAYLOAD_LIMIT = 1024;

  // CRC-32/IEEE, reflected form.
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_GOOD      = 2'd1;
  localparam logic [1:0] KIND_CRC_ERROR = 2'd2;
  localparam logic [1:0] KIND_FORMAT    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] CFG_EXP_VERSION  = 2'd2;
  localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd3;

  // Output bus widths: fields packed from the lowest bit, padded to bytes.
  localparam int OUT_FIELDS_W = 8 + 10 + 8 + 32 + 32 + 11;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [7:0]  expected_version;
    logic [10:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  frame_type;
    logic [31:0] session_word;
    logic [31:0] sequence_word;
    logic [10:0] frame_payload_length;
  } res_t;

  // One byte through the reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/fpd_parser.sv
// ----------------------------------------------------------------------------
// fpd_parser: frame parser
// Sync hunt, header capture, payload forwarding and CRC check for one
// registered byte per cycle while advance holds; at most one result per byte.
// ----------------------------------------------------------------------------
module fpd_parser import fpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [2:0] PH_HUNT0   = 3'd0;
  localparam logic [2:0] PH_HUNT1   = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  logic [2:0]  phase;
  logic [7:0]  hdr [HEADER_BYTES];
  logic [10:0] body_count;
  logic [10:0] length_expected;
  logic [31:0] crc_running;
  logic [31:0] crc_received;
  logic [1:0]  crc_count;

  logic [31:0] crc_next;
  logic [15:0] hdr_len;
  logic        last_hdr;
  logic        fmt_bad;
  logic [10:0] body_inc;
  logic [31:0] crc_word;

  // Datapath terms for the current byte.
  assign crc_next = crc32_byte(crc_running, rx_byte);
  assign hdr_len  = {rx_byte, hdr[10]};
  assign last_hdr = (body_count == 11'(HEADER_BYTES - 1));
  assign fmt_bad  = (hdr[0] != cfg.expected_version) ||
                    (hdr_len > {5'd0, cfg.max_payload}) ||
                    (hdr_len > 16'(PAYLOAD_LIMIT));
  assign body_inc = body_count + 11'd1;
  assign crc_word = {rx_byte, crc_received[23:0]};

  // Result formation; header fields come from the store, except the top
  // length byte on the last header byte, which is the byte at hand.
  always_comb begin
    res_valid                = 1'b0;
    res.kind                 = KIND_PAYLOAD;
    res.payload_byte         = 8'd0;
    res.payload_index        = 10'd0;
    res.frame_type           = hdr[1];
    res.session_word         = {hdr[5], hdr[4], hdr[3], hdr[2]};
    res.sequence_word        = {hdr[9], hdr[8], hdr[7], hdr[6]};
    res.frame_payload_length = (phase == PH_HEADER) ? {rx_byte[2:0], hdr[10]}
                                                    : {hdr[11][2:0], hdr[10]};
    unique case (phase)
      PH_HEADER: begin
        if (last_hdr && fmt_bad) begin
          res_valid = 1'b1;
          res.kind  = KIND_FORMAT;
        end
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = rx_byte;
        res.payload_index = body_count[9:0];
      end
      PH_CRC: begin
        if (crc_count == 2'd3) begin
          res_valid = 1'b1;
          res.kind  = (crc_word == ~crc_running) ? KIND_GOOD : KIND_CRC_ERROR;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Header store, written in arrival order.
  always_ff @(posedge clk) begin
    if (advance && phase == PH_HEADER && body_count < 11'(HEADER_BYTES)) begin
      hdr[body_count[3:0]] <= rx_byte;
    end
  end

  // Phase machine, counters and CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT0;
      body_count      <= 11'd0;
      length_expected <= 11'd0;
      crc_running     <= CRC_INIT;
      crc_received    <= 32'd0;
      crc_count       <= 2'd0;
    end else if (advance) begin
      unique case (phase)
        PH_HUNT0: begin
          if (rx_byte == cfg.magic_first) begin
            phase <= PH_HUNT1;
          end
        end
        PH_HUNT1: begin
          if (rx_byte == cfg.magic_second) begin
            body_count   <= 11'd0;
            crc_count    <= 2'd0;
            crc_received <= 32'd0;
            crc_running  <= CRC_INIT;
            phase        <= PH_HEADER;
          end else if (rx_byte != cfg.magic_first) begin
            phase <= PH_HUNT0;
          end
        end
        PH_HEADER: begin
          crc_running <= crc_next;
          if (last_hdr) begin
            body_count <= 11'd0;
            crc_count  <= 2'd0;
            if (fmt_bad) begin
              phase           <= PH_HUNT0;
              length_expected <= 11'd0;
            end else begin
              length_expected <= hdr_len[10:0];
              phase           <= (hdr_len == 16'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end else begin
            body_count <= body_inc;
          end
        end
        PH_PAYLOAD: begin
          crc_running <= crc_next;
          body_count  <= body_inc;
          if (body_inc >= length_expected) begin
            crc_count    <= 2'd0;
            crc_received <= 32'd0;
            phase        <= PH_CRC;
          end
        end
        PH_CRC: begin
          crc_received[8*crc_count +: 8] <= rx_byte;
          if (crc_count == 2'd3) begin
            phase           <= PH_HUNT0;
            body_count      <= 11'd0;
            length_expected <= 11'd0;
            crc_count       <= 2'd0;
          end else begin
            crc_count <= crc_count + 2'd1;
          end
        end
        default: begin
          phase           <= PH_HUNT0;
          body_count      <= 11'd0;
          length_expected <= 11'd0;
          crc_count       <= 2'd0;
        end
      endcase
    end
  end

  // The header counter never runs past the header.
  a_hdr_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> body_count < 11'(HEADER_BYTES))
    else $error("header count out of range");

  // Payload position stays below the announced length.
  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> body_count < length_expected)
    else $error("payload count reached length");

  // The received CRC word starts empty.
  a_crc_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CRC && crc_count == 2'd0) |-> crc_received == 32'd0)
    else $error("received CRC not cleared");

  // A verdict or format error always sends the parser back to the hunt.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && res.kind != KIND_PAYLOAD) |=> phase == PH_HUNT0)
    else $error("no restart after frame end");

endmodule

// File: rtl/fpd_out_stage.sv
// ----------------------------------------------------------------------------
// fpd_out_stage: result register
// Holds one result item for the output stream and packs it onto the bus.
// ----------------------------------------------------------------------------
module fpd_out_stage import fpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  res_valid,
  input  res_t                  res,
  output logic                  can_load,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // payload_byte[7:0], payload_index[17:8], frame_type[25:18],
  // session_word[57:26], sequence_word[89:58], frame_payload_length[100:90]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // kind[1:0]
  output logic [1:0]            m_tuser
);

  res_t res_q;

  // The register may take a new result when empty or being drained.
  assign can_load = !m_tvalid || m_tready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_q <= res;
    end
  end

  // Bus packing.
  assign m_tuser = res_q.kind;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, res_q.frame_payload_length,
                    res_q.sequence_word, res_q.session_word, res_q.frame_type,
                    res_q.payload_index, res_q.payload_byte};

endmodule

// File: rtl/crc_framed_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc_framed_packet_deframer: sync-word, length and CRC-32 packet deframer
//
//   channel   dir  handshake          contents
//   s_*       in   s_tvalid/s_tready  tdata[7:0] received byte
//   m_*       out  m_tvalid/m_tready  tdata header and payload, tuser kind
//   cfg_*     in   cfg_valid/cfg_ready register index and write data
//
// One byte per cycle is sustained while the output is not stalled; the
// per-byte CRC update and the phase machine sit between the input register
// and the result register. A result is formed from the byte in the input
// register and held in the result register, which offers it on the output.
// Reset is synchronous; it restores the register defaults and the hunt.
// A stalled output stops the parser, and the input register still takes
// one more byte while the result waits.
// ----------------------------------------------------------------------------
module crc_framed_packet_deframer import fpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // rx_byte[7:0]
  input  logic [7:0]            s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // payload_byte[7:0], payload_index[17:8], frame_type[25:18],
  // session_word[57:26], sequence_word[89:58], frame_payload_length[100:90]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // kind[1:0]
  output logic [1:0]            m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [10:0]           cfg_data
);

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       can_load;
  logic       res_valid;
  res_t       res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first      <= 8'hA5;
      cfg.magic_second     <= 8'h5A;
      cfg.expected_version <= 8'h01;
      cfg.max_payload      <= 11'(PAYLOAD_LIMIT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAGIC_FIRST:  cfg.magic_first      <= cfg_data[7:0];
        CFG_MAGIC_SECOND: cfg.magic_second     <= cfg_data[7:0];
        CFG_EXP_VERSION:  cfg.expected_version <= cfg_data[7:0];
        CFG_MAX_PAYLOAD:  cfg.max_payload      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: the parser consumes it when the result register can load.
  assign advance  = in_valid && can_load;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  fpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  fpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
